### rtl/core/obfn_pkg.sv
// Package for the orthonormal frame builder: widths and the threshold reset value.
// No dependencies.
package obfn_pkg;
   localparam int unsigned THRESH_W = 15;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd14746;
endpackage

### rtl/core/obfn_div_stage.sv
// One restoring-division step for the pipelined dividers of the frame builder.
// Depends on nothing; instantiated per quotient bit by the top level.
module obfn_div_stage #(
   parameter int DW = 18
) (
   input  logic [DW-1:0] rem_i,
   input  logic          bit_i,
   input  logic [DW-1:0] den_i,
   output logic [DW-1:0] rem_o,
   output logic          q_o
);
   logic [DW:0] trial;
   assign trial = {rem_i, bit_i};
   always_comb begin
      if (trial >= {1'b0, den_i}) begin
         q_o   = 1'b1;
         rem_o = DW'(trial - {1'b0, den_i});
      end else begin
         q_o   = 1'b0;
         rem_o = trial[DW-1:0];
      end
   end
endmodule

### rtl/core/orthonormal_basis_from_normal.sv
// Frame builder: normalize the request vector, pick a helper axis, build v and u.
// Depends on obfn_pkg.
//
// Usage: pulse req_start with req_vec_x/y/z while req_busy is low. req_busy is
// always low: a new request enters every cycle. The result appears on the
// rsp_ ports for one cycle with rsp_valid high, after 102 register stages at the
// default widths. Each square root is unrolled into one register stage per root
// bit and each division into one stage per dividend bit, so the pipeline depth
// is set by those digit-by-digit units; throughput is one request per cycle.
// The receiver cannot stall; results are produced unconditionally.
// csr_valid/csr_ready write the helper threshold; csr_ready is always high.
// Write it only while the pipeline is empty. Reset (synchronous, active high)
// clears every valid bit and loads the threshold with 0.9 in Q1.14.
// The pipeline is a generic valid-tagged shift structure: every stage register
// carries its valid bit and payload.
module orthonormal_basis_from_normal
   import obfn_pkg::*;
#(
   parameter int FRAC_BITS = 14,
   parameter int IN_WIDTH  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_start,
   output logic                  req_busy,
   input  logic signed [IN_WIDTH-1:0] req_vec_x,
   input  logic signed [IN_WIDTH-1:0] req_vec_y,
   input  logic signed [IN_WIDTH-1:0] req_vec_z,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [THRESH_W-1:0]   csr_helper_switch_threshold,
   output logic                  rsp_valid,
   output logic signed [FRAC_BITS+1:0] rsp_u_x,
   output logic signed [FRAC_BITS+1:0] rsp_u_y,
   output logic signed [FRAC_BITS+1:0] rsp_u_z,
   output logic signed [FRAC_BITS+1:0] rsp_v_x,
   output logic signed [FRAC_BITS+1:0] rsp_v_y,
   output logic signed [FRAC_BITS+1:0] rsp_v_z,
   output logic signed [FRAC_BITS+1:0] rsp_w_x,
   output logic signed [FRAC_BITS+1:0] rsp_w_y,
   output logic signed [FRAC_BITS+1:0] rsp_w_z,
   output logic                  rsp_zero_vector
);
   localparam int OW  = FRAC_BITS + 2;
   // magnitudes and sums for the first normalization
   localparam int MW  = IN_WIDTH;          // magnitude bits
   localparam int SW  = 2*MW + 2;          // sum of three squares
   localparam int RW  = SW/2;              // root bits
   localparam int NB  = SW/2;              // sqrt iterations
   localparam int DNW = MW + FRAC_BITS;    // dividend bits
   // second normalization works on Q1.F values, magnitude <= 2^F
   localparam int M2  = FRAC_BITS + 1;
   localparam int SW2 = 2*M2 + 2;
   localparam int RW2 = SW2/2;
   localparam int NB2 = SW2/2;
   localparam int DNW2 = M2 + FRAC_BITS;
   localparam int PW  = 2*OW + 1;

   typedef struct packed {
      logic              vld;
      logic              zero;
      logic [2:0]        neg;
      logic [2:0][MW-1:0] m;
   } s1_type;

   logic [THRESH_W-1:0] thr_ff;

   assign req_busy  = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESH_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_helper_switch_threshold;
      end
   end

   // ---------------- stage A: magnitudes
   s1_type a_ff;
   logic signed [IN_WIDTH-1:0] vin [3];
   assign vin[0] = req_vec_x;
   assign vin[1] = req_vec_y;
   assign vin[2] = req_vec_z;
   s1_type a_in;
   always_comb begin
      a_in.vld  = req_start;
      a_in.zero = (req_vec_x == '0) && (req_vec_y == '0) && (req_vec_z == '0);
      for (int i = 0; i < 3; i++) begin
         a_in.neg[i] = vin[i][IN_WIDTH-1];
         a_in.m[i]   = vin[i][IN_WIDTH-1] ? MW'(-vin[i]) : MW'(vin[i]);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) a_ff.vld <= 1'b0;
      else       a_ff.vld <= a_in.vld;
      a_ff.zero <= a_in.zero;
      a_ff.neg  <= a_in.neg;
      a_ff.m    <= a_in.m;
   end

   // ---------------- stage B: squares
   logic            b_vld_ff, b_zero_ff;
   logic [2:0]      b_neg_ff;
   logic [2:0][MW-1:0] b_m_ff;
   logic [2:0][2*MW-1:0] b_sq_ff;
   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else       b_vld_ff <= a_ff.vld;
      b_zero_ff <= a_ff.zero;
      b_neg_ff  <= a_ff.neg;
      b_m_ff    <= a_ff.m;
      for (int i = 0; i < 3; i++) b_sq_ff[i] <= a_ff.m[i] * a_ff.m[i];
   end

   // ---------------- stage C: sum
   logic            c_vld_ff, c_zero_ff;
   logic [2:0]      c_neg_ff;
   logic [2:0][MW-1:0] c_m_ff;
   logic [SW-1:0]   c_sum_ff;
   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else       c_vld_ff <= b_vld_ff;
      c_zero_ff <= b_zero_ff;
      c_neg_ff  <= b_neg_ff;
      c_m_ff    <= b_m_ff;
      c_sum_ff  <= SW'(b_sq_ff[0]) + SW'(b_sq_ff[1]) + SW'(b_sq_ff[2]);
   end

   // ---------------- sqrt 1: one result bit per stage
   logic [NB:0]           q1_vld_ff;
   logic [NB:0]           q1_zero_ff;
   logic [NB:0][2:0]      q1_neg_ff;
   logic [NB:0][2:0][MW-1:0] q1_m_ff;
   logic [NB:0][SW-1:0]   q1_n_ff;
   logic [NB:0][RW+1:0]   q1_r_ff;
   logic [NB:0][SW-1:0]   q1_rem_ff;
   always_comb begin
      q1_vld_ff[0]  = c_vld_ff;
      q1_zero_ff[0] = c_zero_ff;
      q1_neg_ff[0]  = c_neg_ff;
      q1_m_ff[0]    = c_m_ff;
      q1_n_ff[0]    = c_sum_ff;
      q1_r_ff[0]    = '0;
      q1_rem_ff[0]  = '0;
   end
   for (genvar k = 0; k < NB; k++) begin : g_sq1
      logic [SW-1:0] rem2;
      logic [SW-1:0] trial;
      always_comb begin
         rem2  = SW'({q1_rem_ff[k], q1_n_ff[k][SW-1 -: 2]});
         trial = SW'({q1_r_ff[k], 2'b01});
      end
      always_ff @(posedge clock) begin
         if (reset) q1_vld_ff[k+1] <= 1'b0;
         else       q1_vld_ff[k+1] <= q1_vld_ff[k];
         q1_zero_ff[k+1] <= q1_zero_ff[k];
         q1_neg_ff[k+1]  <= q1_neg_ff[k];
         q1_m_ff[k+1]    <= q1_m_ff[k];
         q1_n_ff[k+1]    <= q1_n_ff[k] << 2;
         if (rem2 >= trial) begin
            q1_rem_ff[k+1] <= rem2 - trial;
            q1_r_ff[k+1]   <= (RW+2)'({q1_r_ff[k], 1'b1});
         end else begin
            q1_rem_ff[k+1] <= rem2;
            q1_r_ff[k+1]   <= (RW+2)'({q1_r_ff[k], 1'b0});
         end
      end
   end

   // ---------------- divide 1: dividend m<<F by root, one quotient bit per stage
   localparam int DV1 = RW + 1;
   logic [DNW:0]                dv1_vld_ff;
   logic [DNW:0]                dv1_zero_ff;
   logic [DNW:0][2:0]           dv1_neg_ff;
   logic [DNW:0][RW-1:0]        dv1_den_ff;
   logic [DNW:0][2:0][DNW-1:0]  dv1_n_ff;
   logic [DNW:0][2:0][DV1-1:0]  dv1_rem_ff;
   always_comb begin
      dv1_vld_ff[0]  = q1_vld_ff[NB];
      dv1_zero_ff[0] = q1_zero_ff[NB];
      dv1_neg_ff[0]  = q1_neg_ff[NB];
      dv1_den_ff[0]  = RW'(q1_r_ff[NB]);
      for (int i = 0; i < 3; i++) begin
         dv1_n_ff[0][i]   = {q1_m_ff[NB][i], {FRAC_BITS{1'b0}}};
         dv1_rem_ff[0][i] = '0;
      end
   end
   for (genvar k = 0; k < DNW; k++) begin : g_dv1
      for (genvar i = 0; i < 3; i++) begin : g_l
         logic [DV1-1:0] rn;
         logic           qb;
         obfn_div_stage #(.DW(DV1)) u_st (
            .rem_i(dv1_rem_ff[k][i]), .bit_i(dv1_n_ff[k][i][DNW-1]),
            .den_i(DV1'(dv1_den_ff[k])), .rem_o(rn), .q_o(qb));
         always_ff @(posedge clock) begin
            dv1_rem_ff[k+1][i] <= rn;
            dv1_n_ff[k+1][i]   <= {dv1_n_ff[k][i][DNW-2:0], qb};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dv1_vld_ff[k+1] <= 1'b0;
         else       dv1_vld_ff[k+1] <= dv1_vld_ff[k];
         dv1_zero_ff[k+1] <= dv1_zero_ff[k];
         dv1_neg_ff[k+1]  <= dv1_neg_ff[k];
         dv1_den_ff[k+1]  <= dv1_den_ff[k];
      end
   end

   // ---------------- stage W: signed w and helper choice
   logic                    w_vld_ff, w_zero_ff;
   logic [2:0][OW-1:0]      w_ff;
   logic [2:0][OW-1:0]      w_in;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         w_in[i] = dv1_zero_ff[DNW] ? '0 :
                   (dv1_neg_ff[DNW][i] ? OW'(-dv1_n_ff[DNW][i]) : OW'(dv1_n_ff[DNW][i]));
      end
   end
   always_ff @(posedge clock) begin
      if (reset) w_vld_ff <= 1'b0;
      else       w_vld_ff <= dv1_vld_ff[DNW];
      w_zero_ff <= dv1_zero_ff[DNW];
      w_ff      <= w_in;
   end

   // cross(w, helper), kept as sign + magnitude
   logic                 h_vld_ff, h_zero_ff;
   logic [2:0][OW-1:0]   h_w_ff;
   logic [2:0]           h_neg_ff;
   logic [2:0][M2-1:0]   h_m_ff;
   logic [OW-1:0]        wx_mag;
   logic [2:0][OW-1:0]   c_in;
   always_comb begin
      wx_mag = w_ff[0][OW-1] ? OW'(-w_ff[0]) : w_ff[0];
      if (OW'(wx_mag) > OW'(thr_ff)) begin
         c_in[0] = OW'(-w_ff[2]);
         c_in[1] = '0;
         c_in[2] = w_ff[0];
      end else begin
         c_in[0] = '0;
         c_in[1] = w_ff[2];
         c_in[2] = OW'(-w_ff[1]);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) h_vld_ff <= 1'b0;
      else       h_vld_ff <= w_vld_ff;
      h_zero_ff <= w_zero_ff;
      h_w_ff    <= w_ff;
      for (int i = 0; i < 3; i++) begin
         h_neg_ff[i] <= c_in[i][OW-1];
         h_m_ff[i]   <= c_in[i][OW-1] ? M2'(-c_in[i]) : M2'(c_in[i]);
      end
   end

   // squares and sum for the second normalization
   logic                  i_vld_ff, i_zero_ff;
   logic [2:0][OW-1:0]    i_w_ff;
   logic [2:0]            i_neg_ff;
   logic [2:0][M2-1:0]    i_m_ff;
   logic [2:0][2*M2-1:0]  i_sq_ff;
   always_ff @(posedge clock) begin
      if (reset) i_vld_ff <= 1'b0;
      else       i_vld_ff <= h_vld_ff;
      i_zero_ff <= h_zero_ff;
      i_w_ff    <= h_w_ff;
      i_neg_ff  <= h_neg_ff;
      i_m_ff    <= h_m_ff;
      for (int i = 0; i < 3; i++) i_sq_ff[i] <= h_m_ff[i] * h_m_ff[i];
   end
   logic                  j_vld_ff, j_zero_ff;
   logic [2:0][OW-1:0]    j_w_ff;
   logic [2:0]            j_neg_ff;
   logic [2:0][M2-1:0]    j_m_ff;
   logic [SW2-1:0]        j_sum_ff;
   always_ff @(posedge clock) begin
      if (reset) j_vld_ff <= 1'b0;
      else       j_vld_ff <= i_vld_ff;
      j_zero_ff <= i_zero_ff;
      j_w_ff    <= i_w_ff;
      j_neg_ff  <= i_neg_ff;
      j_m_ff    <= i_m_ff;
      j_sum_ff  <= SW2'(i_sq_ff[0]) + SW2'(i_sq_ff[1]) + SW2'(i_sq_ff[2]);
   end

   // ---------------- sqrt 2
   logic [NB2:0]            q2_vld_ff, q2_zero_ff;
   logic [NB2:0][2:0][OW-1:0] q2_w_ff;
   logic [NB2:0][2:0]       q2_neg_ff;
   logic [NB2:0][2:0][M2-1:0] q2_m_ff;
   logic [NB2:0][SW2-1:0]   q2_n_ff;
   logic [NB2:0][RW2+1:0]   q2_r_ff;
   logic [NB2:0][SW2-1:0]   q2_rem_ff;
   always_comb begin
      q2_vld_ff[0]  = j_vld_ff;
      q2_zero_ff[0] = j_zero_ff;
      q2_w_ff[0]    = j_w_ff;
      q2_neg_ff[0]  = j_neg_ff;
      q2_m_ff[0]    = j_m_ff;
      q2_n_ff[0]    = j_sum_ff;
      q2_r_ff[0]    = '0;
      q2_rem_ff[0]  = '0;
   end
   for (genvar k = 0; k < NB2; k++) begin : g_sq2
      logic [SW2-1:0] rem2;
      logic [SW2-1:0] trial;
      always_comb begin
         rem2  = SW2'({q2_rem_ff[k], q2_n_ff[k][SW2-1 -: 2]});
         trial = SW2'({q2_r_ff[k], 2'b01});
      end
      always_ff @(posedge clock) begin
         if (reset) q2_vld_ff[k+1] <= 1'b0;
         else       q2_vld_ff[k+1] <= q2_vld_ff[k];
         q2_zero_ff[k+1] <= q2_zero_ff[k];
         q2_w_ff[k+1]    <= q2_w_ff[k];
         q2_neg_ff[k+1]  <= q2_neg_ff[k];
         q2_m_ff[k+1]    <= q2_m_ff[k];
         q2_n_ff[k+1]    <= q2_n_ff[k] << 2;
         if (rem2 >= trial) begin
            q2_rem_ff[k+1] <= rem2 - trial;
            q2_r_ff[k+1]   <= (RW2+2)'({q2_r_ff[k], 1'b1});
         end else begin
            q2_rem_ff[k+1] <= rem2;
            q2_r_ff[k+1]   <= (RW2+2)'({q2_r_ff[k], 1'b0});
         end
      end
   end

   // ---------------- divide 2; a zero root (degenerate cross) gives v = 0
   localparam int DV2 = RW2 + 1;
   logic [DNW2:0]                 dv2_vld_ff, dv2_zero_ff, dv2_dz_ff;
   logic [DNW2:0][2:0][OW-1:0]    dv2_w_ff;
   logic [DNW2:0][2:0]            dv2_neg_ff;
   logic [DNW2:0][RW2-1:0]        dv2_den_ff;
   logic [DNW2:0][2:0][DNW2-1:0]  dv2_n_ff;
   logic [DNW2:0][2:0][DV2-1:0]   dv2_rem_ff;
   always_comb begin
      dv2_vld_ff[0]  = q2_vld_ff[NB2];
      dv2_zero_ff[0] = q2_zero_ff[NB2];
      dv2_dz_ff[0]   = (q2_r_ff[NB2] == '0);
      dv2_w_ff[0]    = q2_w_ff[NB2];
      dv2_neg_ff[0]  = q2_neg_ff[NB2];
      dv2_den_ff[0]  = RW2'(q2_r_ff[NB2]);
      for (int i = 0; i < 3; i++) begin
         dv2_n_ff[0][i]   = {q2_m_ff[NB2][i], {FRAC_BITS{1'b0}}};
         dv2_rem_ff[0][i] = '0;
      end
   end
   for (genvar k = 0; k < DNW2; k++) begin : g_dv2
      for (genvar i = 0; i < 3; i++) begin : g_l
         logic [DV2-1:0] rn;
         logic           qb;
         obfn_div_stage #(.DW(DV2)) u_st (
            .rem_i(dv2_rem_ff[k][i]), .bit_i(dv2_n_ff[k][i][DNW2-1]),
            .den_i(DV2'(dv2_den_ff[k])), .rem_o(rn), .q_o(qb));
         always_ff @(posedge clock) begin
            dv2_rem_ff[k+1][i] <= rn;
            dv2_n_ff[k+1][i]   <= {dv2_n_ff[k][i][DNW2-2:0], qb};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dv2_vld_ff[k+1] <= 1'b0;
         else       dv2_vld_ff[k+1] <= dv2_vld_ff[k];
         dv2_zero_ff[k+1] <= dv2_zero_ff[k];
         dv2_dz_ff[k+1]   <= dv2_dz_ff[k];
         dv2_w_ff[k+1]    <= dv2_w_ff[k];
         dv2_neg_ff[k+1]  <= dv2_neg_ff[k];
         dv2_den_ff[k+1]  <= dv2_den_ff[k];
      end
   end

   // ---------------- stage V: signed v
   logic                    v_vld_ff, v_zero_ff;
   logic [2:0][OW-1:0]      v_w_ff, v_ff;
   always_ff @(posedge clock) begin
      if (reset) v_vld_ff <= 1'b0;
      else       v_vld_ff <= dv2_vld_ff[DNW2];
      v_zero_ff <= dv2_zero_ff[DNW2];
      v_w_ff    <= dv2_w_ff[DNW2];
      for (int i = 0; i < 3; i++) begin
         v_ff[i] <= (dv2_zero_ff[DNW2] || dv2_dz_ff[DNW2]) ? '0 :
                    (dv2_neg_ff[DNW2][i] ? OW'(-dv2_n_ff[DNW2][i])
                                         : OW'(dv2_n_ff[DNW2][i]));
      end
   end

   // ---------------- stage P: six products of cross(w, v)
   logic                   p_vld_ff, p_zero_ff;
   logic [2:0][OW-1:0]     p_w_ff, p_v_ff;
   logic signed [5:0][PW-1:0] p_ff;
   always_ff @(posedge clock) begin
      if (reset) p_vld_ff <= 1'b0;
      else       p_vld_ff <= v_vld_ff;
      p_zero_ff <= v_zero_ff;
      p_w_ff    <= v_w_ff;
      p_v_ff    <= v_ff;
      p_ff[0] <= PW'($signed(v_w_ff[1]) * $signed(v_ff[2]));
      p_ff[1] <= PW'($signed(v_w_ff[2]) * $signed(v_ff[1]));
      p_ff[2] <= PW'($signed(v_w_ff[2]) * $signed(v_ff[0]));
      p_ff[3] <= PW'($signed(v_w_ff[0]) * $signed(v_ff[2]));
      p_ff[4] <= PW'($signed(v_w_ff[0]) * $signed(v_ff[1]));
      p_ff[5] <= PW'($signed(v_w_ff[1]) * $signed(v_ff[0]));
   end

   // ---------------- output register: difference and floor shift
   logic signed [PW-1:0] d0, d1, d2;
   always_comb begin
      d0 = $signed(p_ff[0]) - $signed(p_ff[1]);
      d1 = $signed(p_ff[2]) - $signed(p_ff[3]);
      d2 = $signed(p_ff[4]) - $signed(p_ff[5]);
   end
   logic                 o_vld_ff, o_zero_ff;
   logic [2:0][OW-1:0]   o_u_ff, o_v_ff, o_w_ff;
   always_ff @(posedge clock) begin
      if (reset) o_vld_ff <= 1'b0;
      else       o_vld_ff <= p_vld_ff;
      o_zero_ff <= p_zero_ff;
      o_v_ff    <= p_v_ff;
      o_w_ff    <= p_w_ff;
      o_u_ff[0] <= OW'(d0 >>> FRAC_BITS);
      o_u_ff[1] <= OW'(d1 >>> FRAC_BITS);
      o_u_ff[2] <= OW'(d2 >>> FRAC_BITS);
   end

   assign rsp_valid       = o_vld_ff;
   assign rsp_zero_vector = o_zero_ff;
   assign rsp_u_x = o_u_ff[0];
   assign rsp_u_y = o_u_ff[1];
   assign rsp_u_z = o_u_ff[2];
   assign rsp_v_x = o_v_ff[0];
   assign rsp_v_y = o_v_ff[1];
   assign rsp_v_z = o_v_ff[2];
   assign rsp_w_x = o_w_ff[0];
   assign rsp_w_y = o_w_ff[1];
   assign rsp_w_z = o_w_ff[2];

   // a zero request yields zero x components on all three axes
   a_zero_axes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |-> (rsp_w_x == '0) && (rsp_v_x == '0) && (rsp_u_x == '0))
      else $error("zero request gave nonzero axes");
   // the output valid is set in the cycle after the product stage valid
   a_out_follow: assert property (@(posedge clock) disable iff (reset)
      p_vld_ff |=> rsp_valid)
      else $error("result dropped at output register");
   // w stage and helper stage stay in lockstep
   a_w_to_h: assert property (@(posedge clock) disable iff (reset)
      w_vld_ff |=> h_vld_ff)
      else $error("request lost between w and helper stages");
endmodule
